// ===== sv/assert_macros.svh =====
// assertion helper macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/ppp_pkg.sv =====
// types and constants for the parallel projection point unit
// no dependencies
package ppp_pkg;
  localparam int unsigned NumRegs = 6;
  localparam logic [2:0] RegScale = 3'd0;
  localparam logic [2:0] RegAlpha = 3'd1;
  localparam logic [2:0] RegBeta = 3'd2;
  localparam logic [2:0] RegGamma = 3'd3;
  localparam logic [2:0] RegShift0 = 3'd4;
  localparam logic [2:0] RegShift1 = 3'd5;

  localparam logic [31:0] QwC1 = 32'd1686629713;
  localparam logic [31:0] QwC3 = 32'd693598667;
  localparam logic [31:0] QwC5 = 32'd85569306;
  localparam logic [31:0] QwC7 = 32'd5026995;
  localparam logic [31:0] QwC9 = 32'd172272;

  typedef struct packed {
    logic signed [17:0] sa;
    logic signed [17:0] ca;
    logic signed [17:0] sb;
    logic signed [17:0] cb;
    logic signed [17:0] sg;
    logic signed [17:0] cg;
    logic [31:0] inv;
    logic signed [31:0] t0;
    logic signed [31:0] t1;
  } coef_t;

  typedef struct packed {
    logic [2:0] index;
    logic [31:0] data;
  } cfg_t;
endpackage

// ===== sv/ppp_if.sv =====
// valid/ready channel interfaces for points, results and register writes
// no dependencies
interface ppp_point_if;
  logic valid;
  logic ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_proj_if;
  logic valid;
  logic ready;
  logic signed [31:0] proj_u;
  logic signed [31:0] proj_v;
  logic clipped;
  modport source (output valid, proj_u, proj_v, clipped, input ready);
  modport sink (input valid, proj_u, proj_v, clipped, output ready);
endinterface

interface ppp_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ppp_setup.sv =====
// register file plus sequential derivation of sines, cosines and reciprocal scale
// depends on ppp_pkg
module ppp_setup
  import ppp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cfg_t wr,
  output coef_t coef,
  output logic busy
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SIN  = 5'b00010,
    S_POLY = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  logic [23:0] scale;
  logic [15:0] ang [3];
  logic [2:0] slot;
  logic [2:0] step;
  logic [31:0] xv, x2, p;
  logic [1:0] quad;
  logic [33:0] rem;
  logic [32:0] quo;
  logic [5:0] dcnt;
  logic signed [17:0] trig [6];
  logic [31:0] inv;
  logic signed [31:0] t0, t1;

  logic [15:0] cur_ang;
  logic [13:0] roff;
  logic [14:0] rsel;
  logic [63:0] prod, sq;
  logic [31:0] x_next;
  logic [31:0] cconst;
  logic [63:0] pr;
  logic [16:0] mag;
  logic [34:0] rem_sh;
  logic [34:0] rem_sub;

  always_comb begin
    cur_ang = ang[slot[2:1]] + (slot[0] ? 16'd16384 : 16'd0);
    roff = cur_ang[13:0];
    rsel = cur_ang[14] ? (15'd16384 - {1'b0, roff}) : {1'b0, roff};
    x_next = {1'b0, rsel, 16'd0};
    sq = x_next * x_next;
    prod = p * x2;
    unique case (step)
      3'd0: cconst = QwC7;
      3'd1: cconst = QwC5;
      3'd2: cconst = QwC3;
      default: cconst = QwC1;
    endcase
    pr = (p * xv) >> 30;
    pr = (pr + 64'd8192) >> 14;
    mag = (pr > 64'd65536) ? 17'd65536 : pr[16:0];
    rem_sh = {rem, quo[32]};
    rem_sub = rem_sh - {11'd0, scale};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_DIV;
      scale <= 24'd65536;
      ang[0] <= '0; ang[1] <= '0; ang[2] <= '0;
      t0 <= '0; t1 <= '0;
      slot <= '0; step <= '0; dcnt <= '0;
      rem <= '0; quo <= 33'h1_0000_8000;
      for (int i = 0; i < 6; i++) trig[i] <= (i % 2 == 1) ? 18'sd65536 : 18'sd0;
      inv <= 32'd65536;
    end else begin
      if (wr_en) begin
        case (wr.index)
          RegScale:  scale <= wr.data[23:0];
          RegAlpha:  ang[0] <= wr.data[15:0];
          RegBeta:   ang[1] <= wr.data[15:0];
          RegGamma:  ang[2] <= wr.data[15:0];
          RegShift0: t0 <= wr.data;
          RegShift1: t1 <= wr.data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (wr_en && wr.index < 3'(NumRegs)) begin
            state <= S_SIN;
            slot <= '0;
          end
        end
        S_SIN: begin
          quad <= cur_ang[15:14];
          xv <= x_next;
          x2 <= sq[61:30];
          p <= QwC9;
          step <= '0;
          state <= S_POLY;
        end
        S_POLY: begin
          if (step == 3'd4) begin
            trig[slot] <= quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            if (slot == 3'd5) begin
              state <= S_DIV;
              dcnt <= '0;
              rem <= '0;
              quo <= (33'h1_0000_0000 + {10'd0, scale[23:1]});
            end else begin
              slot <= slot + 3'd1;
              state <= S_SIN;
            end
          end else begin
            p <= cconst - prod[61:30];
            step <= step + 3'd1;
          end
        end
        S_DIV: begin
          if (rem_sub[34]) begin
            rem <= rem_sh[33:0];
            quo <= {quo[31:0], 1'b0};
          end else begin
            rem <= rem_sub[33:0];
            quo <= {quo[31:0], 1'b1};
          end
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd32) state <= S_DONE;
        end
        S_DONE: begin
          if (scale == 24'd0 || quo[32]) inv <= 32'hFFFF_FFFF;
          else inv <= quo[31:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign coef = '{sa: trig[0], ca: trig[1], sb: trig[2], cb: trig[3],
                  sg: trig[4], cg: trig[5], inv: inv, t0: t0, t1: t1};
endmodule

// ===== sv/parallel_projection_point_unit.sv =====
// top level of the parallel projection point unit: config port, setup and datapath pipeline
// depends on ppp_pkg, ppp_if, ppp_setup and assert_macros.svh
// One point enters per clock while the setup is idle and no write is pending, and its result
// leaves through an eight-stage pipeline in which each stage holds at most one multiply layer
// or one wide add; a stall of the output freezes every stage. After each register write the
// coefficient engine runs six sine evaluations, a restoring divide for the reciprocal scale
// and a load of the result; points and further writes are not accepted during that time, a
// write waits until the pipeline is empty, and after reset the divide and its load run before
// the first point is taken.
`include "assert_macros.svh"
module parallel_projection_point_unit
  import ppp_pkg::*;
(
  input logic clk,
  input logic rst,
  ppp_cfg_if.sink cfg,
  ppp_point_if.sink pin,
  ppp_proj_if.source pout
);
  localparam int Stages = 8;
  coef_t k;
  logic busy;
  cfg_t wr;
  logic wr_en;
  logic [Stages-1:0] vld;
  assign wr = '{index: cfg.index, data: cfg.data};
  assign cfg.ready = !busy && (vld == '0);
  assign wr_en = cfg.valid && cfg.ready;

  ppp_setup u_setup (.clk(clk), .rst(rst), .wr_en(wr_en), .wr(wr), .coef(k), .busy(busy));

  logic adv;
  assign adv = !vld[Stages-1] || pout.ready;
  assign pin.ready = adv && !busy && !cfg.valid;

  logic signed [31:0] x1, y1, z1;
  logic signed [35:0] sasb, casb;
  logic signed [63:0] px, py, pz, qy, qz;
  logic signed [34:0] a3, b3;
  logic signed [16:0] hi_i, lo_i;
  logic signed [51:0] ah, bh, al, bl;
  logic signed [51:0] m1, m2;
  logic f5, f6, f7;
  logic signed [41:0] c1, c2;
  logic signed [63:0] g1, g2, g3, g4;
  logic signed [31:0] u7, v7;

  logic signed [51:0] m1r, m2r;
  logic signed [49:0] usum, vsum;
  localparam logic signed [51:0] Lim = 52'sd1 <<< 40;

  always_comb begin
    m1r = ah + ((al + 52'sd32768) >>> 16) - 52'(k.t0);
    m2r = bh + ((bl + 52'sd32768) >>> 16) - 52'(k.t1);
    usum = 50'((g1 - g2 + 64'sd32768) >>> 16);
    vsum = 50'((g3 + g4 + 64'sd32768) >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Stages-2:0], pin.valid && pin.ready};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1 <= pin.point_x; y1 <= pin.point_y; z1 <= pin.point_z;
      sasb <= 36'((k.sa * k.sb + 36'sd32768) >>> 16);
      casb <= 36'((k.ca * k.sb + 36'sd32768) >>> 16);
      px <= 64'(k.cb * x1);
      py <= 64'(sasb * y1);
      pz <= 64'(casb * z1);
      qy <= 64'(k.ca * y1);
      qz <= 64'(k.sa * z1);
      a3 <= 35'((px + py - pz + 64'sd32768) >>> 16);
      b3 <= 35'((qy + qz + 64'sd32768) >>> 16);
      hi_i <= $signed({1'b0, k.inv[31:16]});
      lo_i <= $signed({1'b0, k.inv[15:0]});
      ah <= a3 * hi_i; al <= a3 * lo_i;
      bh <= b3 * hi_i; bl <= b3 * lo_i;
      m1 <= m1r; m2 <= m2r;
      c1 <= (m1 > Lim) ? 42'sh100_0000_0000 : (m1 < -Lim) ? -42'sh100_0000_0000 : 42'(m1);
      c2 <= (m2 > Lim) ? 42'sh100_0000_0000 : (m2 < -Lim) ? -42'sh100_0000_0000 : 42'(m2);
      f6 <= (m1 > Lim) || (m1 < -Lim) || (m2 > Lim) || (m2 < -Lim);
      g1 <= 64'(k.cg * c1); g2 <= 64'(k.sg * c2);
      g3 <= 64'(k.sg * c1); g4 <= 64'(k.cg * c2);
      f7 <= f6;
      u7 <= (usum > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
            (usum < -50'sh8000_0000) ? 32'sh8000_0000 : usum[31:0];
      v7 <= (vsum > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
            (vsum < -50'sh8000_0000) ? 32'sh8000_0000 : vsum[31:0];
      f5 <= f7 || (usum > 50'sh7FFF_FFFF) || (usum < -50'sh8000_0000) ||
            (vsum > 50'sh7FFF_FFFF) || (vsum < -50'sh8000_0000);
    end
  end

  assign pout.valid = vld[Stages-1];
  assign pout.proj_u = u7;
  assign pout.proj_v = v7;
  assign pout.clipped = f5;

  `ASSERT_IMPL(no_accept_busy, clk, rst, busy, !(pin.valid && pin.ready))
  `ASSERT_NEXT(stall_holds, clk, rst, pout.valid && !pout.ready, pout.valid)
  `ASSERT_IMPL(cfg_quiet, clk, rst, cfg.valid && cfg.ready, vld == '0)
endmodule
